/* rtl/mrr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and sizes for the memory range map retype unit.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // table capacity and derived widths
  localparam int unsigned TABLE_ENTRIES = 128;
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);       // entry index
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);   // entry count
  localparam int unsigned AW = IW + 1;                      // bank + index
  localparam int unsigned XW = (CW > 7) ? CW : 7;           // index compare
  localparam int unsigned PW = CW + 2;                      // count with inserts

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_RETYPE = 2'd2,
    FN_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADARG = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] size;
    logic [7:0]  etype;
  } entry_t;

endpackage : mrr_pkg
`default_nettype wire

/* rtl/mrr_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_req_if
// Request channel: operation code and range arguments.
// ----------------------------------------------------------------------------
interface mrr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] range_start;
  logic [63:0] range_size;
  logic [7:0]  old_type;
  logic [7:0]  new_type;
  logic [6:0]  read_index;

  modport source (output valid, func, range_start, range_size, old_type, new_type,
                  read_index, input ready);
  modport sink   (input valid, func, range_start, range_size, old_type, new_type,
                  read_index, output ready);
endinterface : mrr_req_if
`default_nettype wire

/* rtl/mrr_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_rsp_if
// Response channel: status, entry read back and entry count.
// ----------------------------------------------------------------------------
interface mrr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] entry_start;
  logic [63:0] entry_size;
  logic [7:0]  entry_type;
  logic [7:0]  entry_total;

  modport source (output valid, status, entry_start, entry_size, entry_type,
                  entry_total, input ready);
  modport sink   (input valid, status, entry_start, entry_size, entry_type,
                  entry_total, output ready);
endinterface : mrr_rsp_if
`default_nettype wire

/* rtl/memory_range_map_retype_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_range_map_retype_unit
// Sorted memory range table with clear, append, read and retype operations.
//
//   channel | dir | beat
//   --------+-----+-----------------------------------------------------
//   req_i   | in  | func, range_start, range_size, old_type, new_type, index
//   rsp_o   | out | status, entry_start, entry_size, entry_type, entry_total
//
// Clear, append and rejected requests go straight to the response step, a read
// waits on the RAM first. A retype runs a binary search, a read and a compare
// per step (up to log2(TABLE_ENTRIES)+1 steps), then streams every table entry
// through the split and merge logic into the other bank of the entry RAM (one
// read, one write port). Pieces never exceed TABLE_ENTRIES in total; a refused
// split ends early. No clearing pass after reset. A new request is taken while a
// response still waits; the unit stalls in its last step if the response is not
// taken.
// ----------------------------------------------------------------------------
module memory_range_map_retype_unit
  import mrr_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  mrr_req_if.sink   req_i,
  mrr_rsp_if.source rsp_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_RD_WAIT  = 10'b0000000010,
    S_SRCH_RD  = 10'b0000000100,
    S_SRCH_CMP = 10'b0000001000,
    S_SCAN_RD  = 10'b0000010000,
    S_SCAN_DAT = 10'b0000100000,
    S_SCAN_CLS = 10'b0001000000,
    S_EMIT     = 10'b0010000000,
    S_FLUSH    = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  // entry RAM: two banks, active one selected by bank_q
  entry_t mem [2*TABLE_ENTRIES];
  entry_t rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  entry_t        mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  // control registers
  state_e        state_q, state_d;
  logic          bank_q, bank_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          split_on_q, split_on_d;
  logic          merge_on_q, merge_on_d;
  logic          cur_v_q, cur_v_d;
  logic          out_v_q, out_v_d;

  // datapath registers
  logic [63:0]   s_q, s_d, z_q, z_d, e_q, e_d;
  logic [7:0]    ot_q, ot_d, nt_q, nt_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, j_q, j_d, k0_q, k0_d, wr_q, wr_d;
  logic [PW-1:0] pre_q, pre_d;
  entry_t        ent_q, ent_d;
  logic [63:0]   ee_q, ee_d;
  entry_t        pc_q [3];
  entry_t        pc_d [3];
  logic [63:0]   pe_q [3];
  logic [63:0]   pe_d [3];
  logic [1:0]    pn_q, pn_d, pi_q, pi_d;
  entry_t        cur_q, cur_d;
  logic [63:0]   cur_end_q, cur_end_d;
  logic          cur_in_q, cur_in_d;
  status_e       pst_q, pst_d;
  entry_t        pent_q, pent_d;
  status_e       ost_q, ost_d;
  entry_t        oent_q, oent_d;
  logic [7:0]    otot_q, otot_d;

  // helpers
  logic [64:0]   arg_sum;
  logic          arg_bad;
  logic [CW:0]   lh_sum;
  logic [CW-1:0] mid;
  logic [XW-1:0] idx_x;
  logic          act;
  logic [1:0]    extra;
  logic [PW-1:0] pre_new;
  entry_t        pp;
  logic [63:0]   pp_end;
  logic          do_merge;

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_v_q;
  assign rsp_o.status      = ost_q;
  assign rsp_o.entry_start = oent_q.start;
  assign rsp_o.entry_size  = oent_q.size;
  assign rsp_o.entry_type  = oent_q.etype;
  assign rsp_o.entry_total = otot_q;

  assign arg_sum = {1'b0, req_i.range_start} + {1'b0, req_i.range_size};
  assign arg_bad = (req_i.range_size == 64'd0) || arg_sum[64];
  assign lh_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = lh_sum[CW:1];
  assign idx_x   = XW'(req_i.read_index);
  assign act     = split_on_q && (j_q >= lo_q);
  assign pp      = pc_q[pi_q];
  assign pp_end  = pe_q[pi_q];

  always_comb begin
    state_d    = state_q;
    bank_d     = bank_q;
    cnt_d      = cnt_q;
    split_on_d = split_on_q;
    merge_on_d = merge_on_q;
    cur_v_d    = cur_v_q;
    out_v_d    = out_v_q;
    s_d = s_q; z_d = z_q; e_d = e_q; ot_d = ot_q; nt_d = nt_q;
    lo_d = lo_q; hi_d = hi_q; j_d = j_q; k0_d = k0_q; wr_d = wr_q;
    pre_d = pre_q; ent_d = ent_q; ee_d = ee_q;
    pc_d = pc_q; pe_d = pe_q; pn_d = pn_q; pi_d = pi_q;
    cur_d = cur_q; cur_end_d = cur_end_q; cur_in_d = cur_in_q;
    pst_d = pst_q; pent_d = pent_q;
    ost_d = ost_q; oent_d = oent_q; otot_d = otot_q;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = {bank_q, mid[IW-1:0]};
    extra    = 2'd0;
    pre_new  = pre_q;
    do_merge = 1'b0;

    // response slot frees when taken
    if (out_v_q && rsp_o.ready) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        mem_ra = {bank_q, idx_x[IW-1:0]};
        if (req_i.valid) begin
          s_d    = req_i.range_start;
          z_d    = req_i.range_size;
          e_d    = arg_sum[63:0];
          ot_d   = req_i.old_type;
          nt_d   = req_i.new_type;
          pst_d  = ST_OK;
          pent_d = '0;
          state_d = S_DONE;
          unique case (func_e'(req_i.func))
            FN_CLEAR: begin
              cnt_d = '0;
            end
            FN_APPEND: begin
              if (arg_bad) begin
                pst_d = ST_BADARG;
              end else if (cnt_q >= CW'(TABLE_ENTRIES)) begin
                pst_d = ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = {bank_q, cnt_q[IW-1:0]};
                mem_wd = '{start: req_i.range_start, size: req_i.range_size,
                           etype: req_i.new_type};
                cnt_d  = cnt_q + CW'(1);
              end
            end
            FN_RETYPE: begin
              if (arg_bad || (req_i.old_type == req_i.new_type)) begin
                pst_d = ST_BADARG;
              end else begin
                lo_d    = '0;
                hi_d    = cnt_q;
                state_d = S_SRCH_RD;
              end
            end
            FN_READ: begin
              if (idx_x < XW'(cnt_q)) begin
                state_d = S_RD_WAIT;
              end else begin
                pst_d = ST_BADIDX;
              end
            end
            default: ;
          endcase
        end
      end

      S_RD_WAIT: begin
        pent_d  = rdata_q;
        state_d = S_DONE;
      end

      // binary search for the first entry ending after the start
      S_SRCH_RD: begin
        if (lo_q < hi_q) begin
          state_d = S_SRCH_CMP;
        end else if (lo_q >= cnt_q) begin
          state_d = S_DONE;
        end else begin
          j_d        = '0;
          k0_d       = (lo_q == '0) ? '0 : lo_q - CW'(1);
          wr_d       = '0;
          pre_d      = PW'(cnt_q);
          split_on_d = 1'b1;
          merge_on_d = 1'b1;
          cur_v_d    = 1'b0;
          state_d    = S_SCAN_RD;
        end
      end

      S_SRCH_CMP: begin
        if (s_q < (rdata_q.start + rdata_q.size)) begin
          hi_d = mid;
        end else begin
          lo_d = mid + CW'(1);
        end
        state_d = S_SRCH_RD;
      end

      // stream the active bank through split and merge
      S_SCAN_RD: begin
        mem_ra = {bank_q, j_q[IW-1:0]};
        if (j_q == cnt_q) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_SCAN_DAT;
        end
      end

      S_SCAN_DAT: begin
        ent_d   = rdata_q;
        ee_d    = rdata_q.start + rdata_q.size;
        state_d = S_SCAN_CLS;
      end

      S_SCAN_CLS: begin
        pn_d    = 2'd1;
        pi_d    = 2'd0;
        pc_d[0] = ent_q;
        pe_d[0] = ee_q;
        if (act) begin
          if (ent_q.start >= e_q) begin
            split_on_d = 1'b0;
          end else if ((ent_q.etype == ot_q) && (s_q < ee_q)) begin
            if ((ent_q.start >= s_q) && (ee_q <= e_q)) begin
              pc_d[0].etype = nt_q;
            end else if ((ent_q.start < s_q) && (ee_q > e_q)) begin
              pc_d[0] = '{start: ent_q.start, size: s_q - ent_q.start, etype: ot_q};
              pe_d[0] = s_q;
              pc_d[1] = '{start: s_q, size: z_q, etype: nt_q};
              pe_d[1] = e_q;
              pc_d[2] = '{start: e_q, size: ee_q - e_q, etype: ot_q};
              pe_d[2] = ee_q;
              pn_d    = 2'd3;
              extra   = 2'd2;
            end else if (ent_q.start < s_q) begin
              pc_d[0] = '{start: ent_q.start, size: s_q - ent_q.start, etype: ot_q};
              pe_d[0] = s_q;
              pc_d[1] = '{start: s_q, size: ee_q - s_q, etype: nt_q};
              pe_d[1] = ee_q;
              pn_d    = 2'd2;
              extra   = 2'd1;
            end else begin
              pc_d[0] = '{start: ent_q.start, size: e_q - ent_q.start, etype: nt_q};
              pe_d[0] = e_q;
              pc_d[1] = '{start: e_q, size: ee_q - e_q, etype: ot_q};
              pe_d[1] = ee_q;
              pn_d    = 2'd2;
              extra   = 2'd1;
            end
          end
        end
        pre_new = pre_q + PW'(extra);
        if (pre_new > PW'(TABLE_ENTRIES)) begin
          pst_d   = ST_FULL;
          state_d = S_DONE;
        end else begin
          pre_d   = pre_new;
          state_d = S_EMIT;
        end
      end

      // one piece a cycle into the merge register
      S_EMIT: begin
        if (cur_v_q && cur_in_q && merge_on_q && (cur_q.start >= e_q)) begin
          merge_on_d = 1'b0;
        end
        do_merge = cur_v_q && cur_in_q && merge_on_q && (cur_q.start < e_q) &&
                   (cur_end_q == pp.start) && (cur_q.etype == pp.etype);
        if (do_merge) begin
          cur_d.size = cur_q.size + pp.size;
          cur_end_d  = pp_end;
        end else begin
          if (cur_v_q) begin
            mem_we = 1'b1;
            mem_wa = {~bank_q, wr_q[IW-1:0]};
            mem_wd = cur_q;
            wr_d   = wr_q + CW'(1);
          end
          cur_d     = pp;
          cur_end_d = pp_end;
          cur_in_d  = (j_q >= k0_q);
          cur_v_d   = 1'b1;
        end
        if (pi_q == pn_q - 2'd1) begin
          j_d     = j_q + CW'(1);
          state_d = S_SCAN_RD;
        end else begin
          pi_d = pi_q + 2'd1;
        end
      end

      // write the held entry and switch banks
      S_FLUSH: begin
        if (cur_v_q) begin
          mem_we = 1'b1;
          mem_wa = {~bank_q, wr_q[IW-1:0]};
          mem_wd = cur_q;
        end
        cnt_d   = wr_q + CW'(cur_v_q);
        bank_d  = ~bank_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_v_q || rsp_o.ready) begin
          out_v_d = 1'b1;
          ost_d   = pst_q;
          oent_d  = pent_q;
          otot_d  = 8'(cnt_q);
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      bank_q     <= 1'b0;
      cnt_q      <= '0;
      split_on_q <= 1'b0;
      merge_on_q <= 1'b0;
      cur_v_q    <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      bank_q     <= bank_d;
      cnt_q      <= cnt_d;
      split_on_q <= split_on_d;
      merge_on_q <= merge_on_d;
      cur_v_q    <= cur_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s_q <= s_d; z_q <= z_d; e_q <= e_d; ot_q <= ot_d; nt_q <= nt_d;
    lo_q <= lo_d; hi_q <= hi_d; j_q <= j_d; k0_q <= k0_d; wr_q <= wr_d;
    pre_q <= pre_d; ent_q <= ent_d; ee_q <= ee_d;
    pc_q <= pc_d; pe_q <= pe_d; pn_q <= pn_d; pi_q <= pi_d;
    cur_q <= cur_d; cur_end_q <= cur_end_d; cur_in_q <= cur_in_d;
    pst_q <= pst_d; pent_q <= pent_d;
    ost_q <= ost_d; oent_q <= oent_d; otot_q <= otot_d;
  end

endmodule : memory_range_map_retype_unit
`default_nettype wire
